// ===== rtl/window_permutation_lehmer_rank_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the window permutation Lehmer rank block
// Concurrent checks clocked on aclk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef WINDOW_PERMUTATION_LEHMER_RANK_TOP_ASSERT_SVH
`define WINDOW_PERMUTATION_LEHMER_RANK_TOP_ASSERT_SVH

// Same-cycle implication.
`define WPLR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("wplr assertion failed");

// Next-cycle implication.
`define WPLR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("wplr assertion failed");

`endif

// ===== rtl/wplr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wplr_pkg
// Shared constants, queue entry type and factorial table.
// ----------------------------------------------------------------------------
package wplr_pkg;

    localparam int          MAX_SYMBOLS_DEF  = 12;
    localparam int          SYM_W            = 8;
    localparam int          CNT_W            = 4;
    localparam int          RANK_W           = 29;
    localparam int          DIGIT_W          = 5;
    localparam int          FACT_IDX_W       = 5;
    localparam int          QUEUE_DEPTH      = 2;
    localparam logic [CNT_W-1:0] SYMBOL_COUNT_RST = 4'd12;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic [RANK_W-1:0]  fact;
        logic               bad;
        logic               last;
    } wplr_entry_t;

    // factorials modulo 2^29
    function automatic logic [RANK_W-1:0] fact_mod(input logic [FACT_IDX_W-1:0] idx);
        logic [RANK_W-1:0] f;
        unique case (idx)
            5'd0:    f = 29'd1;
            5'd1:    f = 29'd1;
            5'd2:    f = 29'd2;
            5'd3:    f = 29'd6;
            5'd4:    f = 29'd24;
            5'd5:    f = 29'd120;
            5'd6:    f = 29'd720;
            5'd7:    f = 29'd5040;
            5'd8:    f = 29'd40320;
            5'd9:    f = 29'd362880;
            5'd10:   f = 29'd3628800;
            5'd11:   f = 29'd39916800;
            5'd12:   f = 29'd479001600;
            5'd13:   f = 29'd321440768;
            5'd14:   f = 29'd205203456;
            5'd15:   f = 29'd393697280;
            5'd16:   f = 29'd393576448;
            5'd17:   f = 29'd248348672;
            5'd18:   f = 29'd175308800;
            5'd19:   f = 29'd109641728;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

// ===== rtl/window_permutation_lehmer_rank_top.sv =====
`timescale 1ns / 1ps
// m_tvalid rises when the back pops the last symbol of a window from the queue and registers its result.
// Throughput: one symbol per cycle while the queue is not full; one result per n-1 symbols, n = clamped symbol_count.
// The rate is set by the front's combinational bitmap check and the back's multiply-add.
// Reset (aresetn low, synchronous): symbol_count = 12, window state, queue and output valid cleared.
// A configuration write also clears the window state and the queue.
// ----------------------------------------------------------------------------
// window_permutation_lehmer_rank_top
// Ranks permutation windows of n-1 symbols by their Lehmer code.
// ----------------------------------------------------------------------------
module window_permutation_lehmer_rank_top
    import wplr_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data,   // symbol_count
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,       // [7:0] symbol
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,       // [28:0] rank, [31:29] zero
    output logic [0:0]       m_tuser        // [0] status
);

    wplr_entry_t       push_entry;
    wplr_entry_t       head;
    logic              push;
    logic              full;
    logic              pop;
    logic              not_empty;
    logic [RANK_W-1:0] rank;
    logic              status;

    wplr_front #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_symbol    (s_tdata),
        .q_full      (full),
        .q_push      (push),
        .q_entry     (push_entry)
    );

    wplr_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .flush      (cfg_wr_en),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .not_empty  (not_empty),
        .head       (head)
    );

    wplr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (cfg_wr_en),
        .in_valid (not_empty),
        .in_entry (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_rank   (rank),
        .m_status (status)
    );

    assign m_tdata = {3'b000, rank};
    assign m_tuser = status;

endmodule

// ===== rtl/wplr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wplr_front
// Accepts window symbols, checks range and repeats against the seen bitmap,
// and forms the Lehmer digit and factorial weight of each symbol.
// ----------------------------------------------------------------------------
module wplr_front
    import wplr_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CNT_W-1:0]   cfg_wr_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [SYM_W-1:0]   s_symbol,
    input  logic               q_full,
    output logic               q_push,
    output wplr_entry_t        q_entry
);

    localparam int IDX_W = $clog2(MAX_SYMBOLS);

    logic [CNT_W-1:0]       symbol_count_reg;
    logic [MAX_SYMBOLS-1:0] seen_reg, seen_next;
    logic [IDX_W-1:0]       position_reg, position_next;

    logic                   accept;
    logic                   good;
    logic                   last;
    logic [IDX_W-1:0]       digit;
    logic [FACT_IDX_W-1:0]  fact_idx;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept;

    always_comb begin
        int n_val;
        int x_val;
        logic in_range;
        logic hit;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] smaller;
        logic [MAX_SYMBOLS-1:0] below_mask;

        n_val = int'(symbol_count_reg);
        if (n_val < 2) n_val = 2;
        if (n_val > MAX_SYMBOLS) n_val = MAX_SYMBOLS;
        x_val    = int'(s_symbol);
        in_range = (x_val >= 1) && (x_val <= n_val);
        idx      = IDX_W'(s_symbol - 8'd1);
        hit        = 1'b0;
        below_mask = '0;
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if (i == int'(idx)) hit = seen_reg[i];
            if (i < int'(idx)) below_mask[i] = 1'b1;
        end
        smaller  = IDX_W'($countones(seen_reg & below_mask));
        good     = in_range && !hit;
        digit    = idx - smaller;
        last     = (int'(position_reg) + 1) >= (n_val - 1);
        fact_idx = FACT_IDX_W'(n_val - 1 - int'(position_reg));

        seen_next = seen_reg;
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if (good && (i == int'(idx))) seen_next[i] = 1'b1;
        end
        position_next = position_reg + IDX_W'(1);
    end

    always_comb begin
        q_entry.digit = DIGIT_W'(digit);
        q_entry.fact  = fact_mod(fact_idx);
        q_entry.bad   = !good;
        q_entry.last  = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            symbol_count_reg <= SYMBOL_COUNT_RST;
            seen_reg         <= '0;
            position_reg     <= '0;
        end else if (cfg_wr_en) begin
            symbol_count_reg <= cfg_wr_data;
            seen_reg         <= '0;
            position_reg     <= '0;
        end else if (accept) begin
            if (last) begin
                seen_reg     <= '0;
                position_reg <= '0;
            end else begin
                seen_reg     <= seen_next;
                position_reg <= position_next;
            end
        end
    end

endmodule

// ===== rtl/wplr_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wplr_fifo
// Short queue of classified symbols between front and back.
// ----------------------------------------------------------------------------
module wplr_fifo
    import wplr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        flush,
    input  logic        push,
    input  wplr_entry_t push_entry,
    output logic        full,
    input  logic        pop,
    output logic        not_empty,
    output wplr_entry_t head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CT_W  = $clog2(QUEUE_DEPTH + 1);

    wplr_entry_t      mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == CT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + CT_W'(1);
        if (pop && !push) count_next = count_reg - CT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || flush) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/wplr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wplr_back
// Accumulates digit times factorial, and registers the rank and status at
// the end of each window.
// ----------------------------------------------------------------------------
module wplr_back
    import wplr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clear,
    input  logic              in_valid,
    input  wplr_entry_t       in_entry,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [RANK_W-1:0] m_rank,
    output logic              m_status
);

    logic [RANK_W-1:0] rank_sum_reg;
    logic              bad_reg;
    logic              out_valid_reg;
    logic [RANK_W-1:0] out_rank_reg;
    logic              out_status_reg;

    logic [RANK_W-1:0] product;
    logic [RANK_W-1:0] sum_next;
    logic              bad_next;

    assign pop = in_valid && (!in_entry.last || !out_valid_reg || m_tready);

    always_comb begin
        product  = RANK_W'(in_entry.digit * in_entry.fact);
        sum_next = rank_sum_reg + product;
        bad_next = bad_reg | in_entry.bad;
    end

    assign m_tvalid = out_valid_reg;
    assign m_rank   = out_rank_reg;
    assign m_status = out_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            rank_sum_reg <= '0;
            bad_reg      <= 1'b0;
        end else if (pop) begin
            if (in_entry.last) begin
                rank_sum_reg <= '0;
                bad_reg      <= 1'b0;
            end else begin
                rank_sum_reg <= sum_next;
                bad_reg      <= bad_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop && in_entry.last) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && in_entry.last) begin
            out_rank_reg   <= bad_next ? '0 : sum_next;
            out_status_reg <= bad_next;
        end
    end

`include "window_permutation_lehmer_rank_top_assert.svh"

    `WPLR_ASSERT_NOW(a_bad_rank_zero, aclk, aresetn, out_valid_reg && out_status_reg, out_rank_reg == '0)
    `WPLR_ASSERT_NEXT(a_last_gives_result, aclk, aresetn, pop && in_entry.last, out_valid_reg)
    `WPLR_ASSERT_NEXT(a_clear_resets_sum, aclk, aresetn, clear, rank_sum_reg == '0 && !bad_reg)
    `WPLR_ASSERT_NEXT(a_idle_sum_holds, aclk, aresetn, !in_valid && !clear, $stable(rank_sum_reg))

endmodule
